### design/bbd_pkg.sv
// ----------------------------------------------------------------------------
// bbd_pkg: shared types and helpers for the bilinear Bayer demosaic unit
// Sizes, pipeline item and result types, and the per-pixel color
// reconstruction used by the window stage.
// ----------------------------------------------------------------------------
package bbd_pkg;

  // line buffer depth (maximum pixels per row)
  localparam int unsigned MAX_WIDTH = 256;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned CFG_W     = 9;
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  // width used for compares between the register and the buffer depth
  localparam int unsigned CMP_W     = ($clog2(MAX_WIDTH + 1) > CFG_W) ?
                                      $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int unsigned LINE_W    = 2 * PIX_W;
  localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(256);

  // output queue sizing
  localparam int unsigned FIFO_DEPTH = 3;
  localparam int unsigned FPTR_W     = 2;

  typedef logic [COL_W-1:0] col_t;
  typedef logic [PIX_W-1:0] pix_t;

  // 3x3 window, [row 0 top .. 2 bottom][col 0 left .. 2 right]
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  // one accepted beat with its position context
  typedef struct packed {
    logic       drain;
    pix_t       pix;
    col_t       col;
    logic [1:0] rows_seen;
    logic       parity;
    logic       row_end;
  } item_t;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
    logic last_in_run;
    logic frame_done;
  } result_t;

  // results produced by one window step
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

  // window stage status toward the front end
  typedef struct packed {
    logic valid;
    logic fire;
    col_t col;
  } s1_status_t;

  typedef struct packed {
    logic              we;
    col_t              addr;
    logic [LINE_W-1:0] data;
  } ram_wr_t;

  // Bilinear reconstruction of the center pixel of a window.
  function automatic result_t emit_pixel(win_t w, logic even_row, logic even_col);
    result_t r;
    pix_t    cen;
    pix_t    cross_avg;
    pix_t    diag;
    pix_t    vert;
    pix_t    horz;
    cen       = w[1][1];
    cross_avg = pix_t'(w[1][0] >> 2) + pix_t'(w[1][2] >> 2) +
                pix_t'(w[0][1] >> 2) + pix_t'(w[2][1] >> 2);
    diag  = pix_t'(w[0][0] >> 2) + pix_t'(w[0][2] >> 2) +
            pix_t'(w[2][0] >> 2) + pix_t'(w[2][2] >> 2);
    vert  = pix_t'(w[0][1] >> 1) + pix_t'(w[2][1] >> 1);
    horz  = pix_t'(w[1][0] >> 1) + pix_t'(w[1][2] >> 1);
    r.last_in_run = 1'b0;
    r.frame_done  = 1'b0;
    if (even_row) begin
      if (even_col) begin
        r.red = cen;  r.green = cross_avg; r.blue = diag;
      end else begin
        r.red = horz; r.green = cen;       r.blue = vert;
      end
    end else begin
      if (even_col) begin
        r.red = vert; r.green = cen;       r.blue = horz;
      end else begin
        r.red = diag; r.green = cross_avg; r.blue = cen;
      end
    end
    return r;
  endfunction

endpackage

### design/bilinear_bayer_demosaic_unit.sv
// ----------------------------------------------------------------------------
// bilinear_bayer_demosaic_unit: streaming RGGB bilinear demosaic
// Raw Bayer pixels in raster order in, one RGB pixel out per raw pixel.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o): one beat per raw pixel, mode_i=1
//    marks a drain beat acting as a zero pixel; after the last image row send
//    one full row of drain beats to flush the frame.
//  - Output channel (out_valid_o/out_ready_i): RGB results in raster order.
//    A pixel's result follows the beat at one row plus one pixel later; the
//    last beat of each row gives two results. frame_done_o marks the last one.
//  - cfg_we_i/cfg_wdata_i set the row width; write only while idle.
//  - Throughput: one beat per cycle while the sink keeps up. A beat passes the
//    window stage register and a read-modify-write of a single line buffer RAM
//    (both previous rows in one word, registered read), then a 3-entry output
//    queue. A row end pushes two results but the next row's first beat pushes
//    none, so a one-per-cycle sink keeps the input at one beat per cycle.
//  - A stalled sink fills the output queue, then the window stage and then
//    in_ready_o drop; nothing is lost.
//  - Reset clears counters, the window and the queue; the line RAM is not
//    cleared (rows above the image are read but masked to zero).
// ----------------------------------------------------------------------------
module bilinear_bayer_demosaic_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bbd_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       mode_i,
  input  logic [bbd_pkg::PIX_W-1:0]  raw_pixel_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [bbd_pkg::PIX_W-1:0]  red_o,
  output logic [bbd_pkg::PIX_W-1:0]  green_o,
  output logic [bbd_pkg::PIX_W-1:0]  blue_o,
  output logic                       last_in_run_o,
  output logic                       frame_done_o
);
  import bbd_pkg::*;

  logic [CFG_W-1:0]  width_q;
  col_t              col_q;
  logic [1:0]        rows_q;
  logic              parity_q;
  logic [CMP_W-1:0]  width_ext;
  logic [CMP_W-1:0]  eff_w;
  logic              row_end;
  logic              in_fire;
  item_t             item;
  s1_status_t        s1_stat;
  ram_wr_t           ram_wr;
  col_t              ram_raddr;
  logic [LINE_W-1:0] ram_rdata;
  push_t             push;
  logic [1:0]        fifo_free;
  result_t           out_res;

  // effective width clamp to [2, MAX_WIDTH]
  always_comb begin
    width_ext = CMP_W'(width_q);
    if (width_ext < CMP_W'(2)) begin
      eff_w = CMP_W'(2);
    end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
      eff_w = CMP_W'(MAX_WIDTH);
    end else begin
      eff_w = width_ext;
    end
  end

  assign row_end    = (CMP_W'(col_q) + CMP_W'(1)) >= eff_w;
  assign in_ready_o = !s1_stat.valid || s1_stat.fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // beat with position context
  assign item.drain     = mode_i;
  assign item.pix       = mode_i ? '0 : raw_pixel_i;
  assign item.col       = col_q;
  assign item.rows_seen = rows_q;
  assign item.parity    = parity_q;
  assign item.row_end   = row_end;

  // config register and raster position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      col_q    <= '0;
      rows_q   <= '0;
      parity_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        if (row_end) begin
          col_q <= '0;
          if (mode_i) begin
            rows_q   <= '0;
            parity_q <= 1'b0;
          end else begin
            if (!rows_q[1]) begin
              rows_q <= rows_q + 2'd1;
            end
            parity_q <= ~parity_q;
          end
        end else begin
          col_q <= col_q + COL_W'(1);
        end
      end
    end
  end

  // a held stage re-reads its own entry so the read data stays current
  assign ram_raddr = (s1_stat.valid && !s1_stat.fire) ? s1_stat.col : col_q;

  bbd_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bbd_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .item_i      (item),
    .ram_rdata_i (ram_rdata),
    .fifo_free_i (fifo_free),
    .status_o    (s1_stat),
    .ram_wr_o    (ram_wr),
    .push_o      (push)
  );

  bbd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .free_o      (fifo_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res)
  );

  assign red_o         = out_res.red;
  assign green_o       = out_res.green;
  assign blue_o        = out_res.blue;
  assign last_in_run_o = out_res.last_in_run;
  assign frame_done_o  = out_res.frame_done;

  // write-back never hits the entry being read
  a_ram_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_wr.we |-> ram_wr.addr != ram_raddr)
    else $error("line RAM write and read address collide");

  // a held window stage keeps its item
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_stat.valid && !s1_stat.fire |=> s1_stat.valid && s1_stat.col == $past(s1_stat.col))
    else $error("window stage lost a held item");

  // frame end is always the last result of its beat
  a_frame_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> last_in_run_o)
    else $error("frame_done without last_in_run");

  // results only come from a stepping window stage
  a_push_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.count != 2'd0 |-> s1_stat.fire && push.count <= fifo_free)
    else $error("result push without room or step");

endmodule

### design/bbd_ram.sv
// ----------------------------------------------------------------------------
// bbd_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/bbd_window.sv
// ----------------------------------------------------------------------------
// bbd_window: window stage of the demosaic unit
// Takes the line buffer read data, shifts the 3x3 window, writes the rows
// back and forms up to two RGB results per beat.
// ----------------------------------------------------------------------------
module bbd_window (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_fire_i,
  input  bbd_pkg::item_t     item_i,
  input  logic [bbd_pkg::LINE_W-1:0] ram_rdata_i,
  input  logic [1:0]         fifo_free_i,
  output bbd_pkg::s1_status_t status_o,
  output bbd_pkg::ram_wr_t   ram_wr_o,
  output bbd_pkg::push_t     push_o
);
  import bbd_pkg::*;

  item_t      s1_q;
  logic       s1_valid_q;
  win_t       win_q;
  win_t       win_new;
  win_t       win_base;
  win_t       win_end;
  pix_t       above;
  pix_t       two;
  logic       has_mid;
  logic       has_end;
  logic [1:0] need;
  logic       fire;
  result_t    res_mid;
  result_t    res_end;

  // masked line data: rows above the image read as zero
  assign above = (s1_q.rows_seen != 2'd0) ? ram_rdata_i[LINE_W-1:PIX_W] : '0;
  assign two   = s1_q.rows_seen[1] ? ram_rdata_i[PIX_W-1:0] : '0;

  // window shift, cleared at the row start; end window pads zeros at right
  always_comb begin
    win_base = (s1_q.col == '0) ? '0 : win_q;
    win_new[0][2] = two;
    win_new[1][2] = above;
    win_new[2][2] = s1_q.pix;
    for (int r = 0; r < 3; r++) begin
      win_new[r][0] = win_base[r][1];
      win_new[r][1] = win_base[r][2];
      win_end[r][0] = win_new[r][1];
      win_end[r][1] = win_new[r][2];
      win_end[r][2] = '0;
    end
  end

  // result count and step condition against queue room
  assign has_mid = (s1_q.rows_seen != 2'd0) && (s1_q.col != '0);
  assign has_end = (s1_q.rows_seen != 2'd0) && s1_q.row_end;
  assign need    = {1'b0, has_mid} + {1'b0, has_end};
  assign fire    = s1_valid_q && (need <= fifo_free_i);

  // color reconstruction
  always_comb begin
    res_mid = emit_pixel(win_new, s1_q.parity, s1_q.col[0]);
    res_end = emit_pixel(win_end, s1_q.parity, ~s1_q.col[0]);
    res_end.frame_done  = s1_q.drain;
    res_end.last_in_run = 1'b1;
    res_mid.last_in_run = ~has_end;
    push_o.count = fire ? need : 2'd0;
    if (has_mid) begin
      push_o.res0 = res_mid;
      push_o.res1 = res_end;
    end else begin
      push_o.res0 = res_end;
      push_o.res1 = res_end;
    end
  end

  // write back: current row moves to line_above, old line_above moves down
  assign ram_wr_o.we   = fire;
  assign ram_wr_o.addr = s1_q.col;
  assign ram_wr_o.data = {s1_q.pix, ram_rdata_i[LINE_W-1:PIX_W]};

  assign status_o.valid = s1_valid_q;
  assign status_o.fire  = fire;
  assign status_o.col   = s1_q.col;

  // stage valid and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      win_q      <= '0;
    end else begin
      if (in_fire_i) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (fire) begin
        win_q <= win_new;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      s1_q <= item_i;
    end
  end

endmodule

### design/bbd_out_fifo.sv
// ----------------------------------------------------------------------------
// bbd_out_fifo: output result queue
// Three-entry queue taking up to two results per cycle, one beat out.
// ----------------------------------------------------------------------------
module bbd_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bbd_pkg::push_t   push_i,
  output logic [1:0]       free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bbd_pkg::result_t out_res_o
);
  import bbd_pkg::*;

  result_t           mem_q [FIFO_DEPTH];
  logic [FPTR_W-1:0] wptr_q;
  logic [FPTR_W-1:0] rptr_q;
  logic [1:0]        cnt_q;
  logic              pop;
  logic [FPTR_W-1:0] wptr_nx;

  function automatic logic [FPTR_W-1:0] ptr_inc(logic [FPTR_W-1:0] p);
    return (p == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FPTR_W'(1);
  endfunction

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_res_o   = mem_q[rptr_q];
  assign free_o      = 2'(FIFO_DEPTH) - cnt_q;
  assign wptr_nx     = ptr_inc(wptr_q);

  // entry writes
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wptr_q] <= push_i.res0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wptr_nx] <= push_i.res1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i.count == 2'd1) begin
        wptr_q <= wptr_nx;
      end else if (push_i.count == 2'd2) begin
        wptr_q <= ptr_inc(wptr_nx);
      end
      if (pop) begin
        rptr_q <= ptr_inc(rptr_q);
      end
      cnt_q <= cnt_q + push_i.count - {1'b0, pop};
    end
  end

endmodule

### tb/bbd_rgb_checker_pkg.sv
// ----------------------------------------------------------------------------
// bbd_rgb_checker_pkg: RGB scoreboard for the bilinear Bayer demosaic unit
// Mirrors the line buffers, the 3x3 window and the row counters of the unit.
// Each accepted raw beat is turned into the RGB beats it should produce,
// and those beats are compared in order with what the unit sends out.
// ----------------------------------------------------------------------------
package bbd_rgb_checker_pkg;

  import bbd_pkg::*;

  // input beat kinds
  localparam bit MODE_RAW   = 1'b0;
  localparam bit MODE_DRAIN = 1'b1;

  class rgb_scoreboard;
    pix_t             above_row[MAX_WIDTH];
    pix_t             two_above_row[MAX_WIDTH];
    pix_t             win[3][3];
    int unsigned      col;
    int unsigned      rows_seen;
    bit               parity;
    logic [CFG_W-1:0] width_reg;
    result_t          rgb_due_q[$];
    int unsigned      errors;

    function new();
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          win[r][c] = '0;
      col       = 0;
      rows_seen = 0;
      parity    = 1'b0;
      width_reg = WIDTH_RESET;
      errors    = 0;
    endfunction

    function void set_width(logic [CFG_W-1:0] w);
      width_reg = w;
    endfunction

    // register value clamped to [2, MAX_WIDTH]
    function int unsigned eff_width();
      int unsigned w;
      w = width_reg;
      if (w < 2) w = 2;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
    endfunction

    function int unsigned pending();
      return rgb_due_q.size();
    endfunction

    function bit at_frame_start();
      return (col == 0) && (rows_seen == 0);
    endfunction

    // new right-hand column: top, middle, bottom
    function void shift_window(pix_t top, pix_t mid, pix_t bot);
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = bot;
    endfunction

    // bilinear color of the window center; terms truncated before the sum
    function result_t interpolate_center(bit even_row, bit even_col);
      result_t     r;
      int unsigned cen, up, dn, lf, rt;
      int unsigned cross_sum, diag, vert, horz;
      cen   = win[1][1];
      up    = win[0][1];
      dn    = win[2][1];
      lf    = win[1][0];
      rt    = win[1][2];
      cross_sum = lf / 4 + rt / 4 + up / 4 + dn / 4;
      diag  = win[0][0] / 4 + win[0][2] / 4 + win[2][0] / 4 + win[2][2] / 4;
      vert  = up / 2 + dn / 2;
      horz  = lf / 2 + rt / 2;
      r.last_in_run = 1'b0;
      r.frame_done  = 1'b0;
      if (even_row) begin
        if (even_col) begin
          r.red = pix_t'(cen);  r.green = pix_t'(cross_sum); r.blue = pix_t'(diag);
        end else begin
          r.red = pix_t'(horz); r.green = pix_t'(cen);       r.blue = pix_t'(vert);
        end
      end else begin
        if (even_col) begin
          r.red = pix_t'(vert); r.green = pix_t'(cen);       r.blue = pix_t'(horz);
        end else begin
          r.red = pix_t'(diag); r.green = pix_t'(cross_sum); r.blue = pix_t'(cen);
        end
      end
      return r;
    endfunction

    // one accepted input beat: update state, queue the RGB beats it causes
    function void note_raw_beat(bit mode, pix_t raw);
      bit          drain;
      pix_t        pix, above, two;
      int unsigned x;
      bit          out_even_row;
      bit          row_end;
      bit          has_mid, has_end;
      result_t     mid_rgb, end_rgb;
      drain        = (mode == MODE_DRAIN);
      pix          = drain ? '0 : raw;
      x            = col;
      out_even_row = parity;
      row_end      = (x + 1 >= eff_width());
      has_mid      = 1'b0;
      has_end      = 1'b0;

      // rows above the frame read as zero
      above = (rows_seen >= 1) ? above_row[x] : '0;
      two   = (rows_seen >= 2) ? two_above_row[x] : '0;
      two_above_row[x] = above_row[x];
      above_row[x]     = pix;

      if (x == 0)
        for (int r = 0; r < 3; r++)
          for (int c = 0; c < 3; c++)
            win[r][c] = '0;
      shift_window(two, above, pix);

      // pixel one to the left
      if (rows_seen >= 1 && x >= 1) begin
        mid_rgb = interpolate_center(out_even_row, ((x - 1) & 1) == 0);
        has_mid = 1'b1;
      end

      // row end: last pixel sees zeros on its right
      if (row_end) begin
        if (rows_seen >= 1) begin
          shift_window('0, '0, '0);
          end_rgb = interpolate_center(out_even_row, (x & 1) == 0);
          end_rgb.frame_done = drain;
          has_end = 1'b1;
        end
        col = 0;
        if (drain) begin
          rows_seen = 0;
          parity    = 1'b0;
        end else begin
          if (rows_seen < 2) rows_seen++;
          parity = ~parity;
        end
      end else begin
        col = x + 1;
      end

      if (has_end) end_rgb.last_in_run = 1'b1;
      else if (has_mid) mid_rgb.last_in_run = 1'b1;
      if (has_mid) rgb_due_q.push_back(mid_rgb);
      if (has_end) rgb_due_q.push_back(end_rgb);
    endfunction

    // one accepted output beat against the oldest expected one
    function void check_rgb_beat(pix_t red, pix_t green, pix_t blue,
                                 logic last_in_run, logic frame_done);
      result_t want;
      if (rgb_due_q.size() == 0) begin
        $error("unexpected RGB beat: red %0d green %0d blue %0d", red, green, blue);
        errors++;
      end else begin
        want = rgb_due_q.pop_front();
        if (red !== want.red) begin
          $error("red: expected %0d, actual %0d", want.red, red);
          errors++;
        end
        if (green !== want.green) begin
          $error("green: expected %0d, actual %0d", want.green, green);
          errors++;
        end
        if (blue !== want.blue) begin
          $error("blue: expected %0d, actual %0d", want.blue, blue);
          errors++;
        end
        if (last_in_run !== want.last_in_run) begin
          $error("last_in_run: expected %0d, actual %0d", want.last_in_run, last_in_run);
          errors++;
        end
        if (frame_done !== want.frame_done) begin
          $error("frame_done: expected %0d, actual %0d", want.frame_done, frame_done);
          errors++;
        end
      end
    endfunction
  endclass

endpackage

### tb/tb_bilinear_bayer_demosaic_unit.sv
// ----------------------------------------------------------------------------
// tb_bilinear_bayer_demosaic_unit: stream test of the bilinear demosaic unit
// Drives raw and drain beats in bursts over several row widths, stalls the
// RGB side on changing patterns, and checks every RGB beat in order.
// ----------------------------------------------------------------------------
module tb_bilinear_bayer_demosaic_unit;

  timeunit 1ns;
  timeprecision 1ps;

  import bbd_pkg::*;
  import bbd_rgb_checker_pkg::*;

  localparam int unsigned RANDOM_BEATS = 1750;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYC   = 8;
  localparam int unsigned TAIL_CYC     = 16;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  logic             mode_i      = MODE_RAW;
  pix_t             raw_pixel_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  pix_t             red_o;
  pix_t             green_o;
  pix_t             blue_o;
  logic             last_in_run_o;
  logic             frame_done_o;

  rgb_scoreboard chk = new();

  int unsigned burst_left = 0;
  int unsigned beats_sent = 0;

  // sink stall pattern state
  int unsigned stall_mode  = 0;
  int unsigned stall_left  = 0;
  int unsigned stall_hold  = 0;
  int unsigned stall_tick  = 0;
  int unsigned stall_every = 3;

  bilinear_bayer_demosaic_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .raw_pixel_i   (raw_pixel_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .last_in_run_o (last_in_run_o),
    .frame_done_o  (frame_done_o)
  );

  always #2 clk_i = ~clk_i;

  // sink ready: always on, coin flip, periodic, or long stalls
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode  = $urandom_range(0, 3);
      stall_left  = $urandom_range(20, 200);
      stall_every = $urandom_range(2, 5);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= $urandom_range(0, 1);
      2: out_ready_i <= (stall_tick % stall_every) != 0;
      default: begin
        if (stall_hold > 0) begin
          stall_hold--;
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
          if ($urandom_range(0, 15) == 0) stall_hold = $urandom_range(5, 24);
        end
      end
    endcase
  end

  // RGB beat monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      chk.check_rgb_beat(red_o, green_o, blue_o, last_in_run_o, frame_done_o);
  end

  // watchdog: cycles without any beat on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("bilinear_bayer_demosaic_unit: mismatch");
    $finish;
  end

  function automatic pix_t rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  // one input beat; bursts of random length with random gaps between them
  task automatic send_beat(bit m, pix_t p);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(40, 120);
      end else begin
        gap        = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 16);
      end
    end
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    mode_i      = m;
    raw_pixel_i = p;
    do @(posedge clk_i); while (!in_ready_o);
    chk.note_raw_beat(m, p);
    burst_left--;
    beats_sent++;
  endtask

  // hold the sender until every expected RGB beat is out, then settle
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (chk.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_width(logic [CFG_W-1:0] w);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = w;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    chk.set_width(w);
  endtask

  // drain ticks until the frame restarts
  task automatic close_frame();
    do send_beat(MODE_DRAIN, rand_pixel()); while (!chk.at_frame_start());
  endtask

  // image rows, optionally a cut-off row, then the drain row
  task automatic run_frame(int unsigned image_rows, bit cut_short);
    int unsigned w, hole;
    w = chk.eff_width();
    for (int unsigned r = 0; r < image_rows; r++) begin
      // now and then a drain tick inside the row acts as a zero pixel
      hole = ($urandom_range(0, 7) == 0) ? $urandom_range(0, w - 2) : w;
      for (int unsigned c = 0; c < w; c++)
        send_beat((c == hole) ? MODE_DRAIN : MODE_RAW, rand_pixel());
    end
    if (cut_short)
      repeat ($urandom_range(1, w - 1)) send_beat(MODE_RAW, rand_pixel());
    close_frame();
  endtask

  initial begin
    bit               dir_mode[20];
    pix_t             dir_pix[20];
    logic [CFG_W-1:0] new_w;
    int unsigned      frames;
    int unsigned      rand_start;

    // width 2: full frame, empty frame, one-row frame, drain inside a frame
    dir_mode = '{MODE_RAW, MODE_RAW, MODE_RAW, MODE_RAW, MODE_RAW, MODE_RAW,
                 MODE_DRAIN, MODE_DRAIN,
                 MODE_DRAIN, MODE_DRAIN,
                 MODE_RAW, MODE_RAW, MODE_DRAIN, MODE_DRAIN,
                 MODE_RAW, MODE_RAW, MODE_DRAIN, MODE_RAW, MODE_DRAIN, MODE_DRAIN};
    dir_pix  = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255,
                 8'd255, 8'd255,
                 8'd0, 8'd255,
                 8'd170, 8'd85, 8'd255, 8'd0,
                 8'd1, 8'd254, 8'd255, 8'd128, 8'd255, 8'd255};

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part
    write_width(CFG_W'(2));
    for (int i = 0; i < 20; i++) send_beat(dir_mode[i], dir_pix[i]);

    // widest rows, register above the line buffer depth
    rand_start = beats_sent;
    write_width(CFG_W'(511));
    run_frame(2, 1'b0);

    // small widths, clamped values among them
    while (beats_sent < rand_start + RANDOM_BEATS) begin
      case ($urandom_range(0, 5))
        0: new_w = CFG_W'(0);
        1: new_w = CFG_W'(1);
        2: new_w = CFG_W'(3);
        default: new_w = CFG_W'($urandom_range(2, 40));
      endcase
      write_width(new_w);
      frames = $urandom_range(1, 4);
      repeat (frames) begin
        run_frame($urandom_range(0, 6), $urandom_range(0, 9) == 0);
        if ($urandom_range(0, 3) == 0) wait_idle();
      end
    end

    // drain remaining RGB beats, then a short tail
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (chk.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYC) @(posedge clk_i);

    if (chk.errors == 0 && chk.pending() == 0)
      $display("bilinear_bayer_demosaic_unit: match");
    else
      $display("bilinear_bayer_demosaic_unit: mismatch");
    $finish;
  end

endmodule
